// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the trace ring buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define TEBR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, disabled during reset
`define TEBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TEBR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define TEBR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/tebr_pkg.sv -----
// ----------------------------------------------------------------------------
// tebr_pkg
// Types and constants of the trace event ring buffer.
// ----------------------------------------------------------------------------
package tebr_pkg;

   localparam logic [1:0] OP_LOG   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_SETUP = 2'd2;

   localparam logic [1:0] FILT_NONE     = 2'd0;
   localparam logic [1:0] FILT_CLASS    = 2'd1;
   localparam logic [1:0] FILT_SUBCLASS = 2'd2;
   localparam logic [1:0] FILT_RANGE    = 2'd3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_ENABLE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_WRAP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_FIRST   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_SECOND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_ENTRIES = 3'd5;

   localparam int              BUF_ENTRIES_W   = 14;
   localparam logic [13:0]     BUF_ENTRIES_RST = 14'd8192;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] event_id;
      logic [31:0] arg_one;
      logic [31:0] arg_two;
      logic [31:0] arg_three;
      logic [31:0] arg_four;
      logic [31:0] thread_tag;
      logic [63:0] time_now;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [31:0] out_event_id;
      logic [31:0] out_arg_one;
      logic [31:0] out_arg_two;
      logic [31:0] out_arg_three;
      logic [31:0] out_arg_four;
      logic [31:0] out_thread_tag;
      logic [63:0] out_time;
      logic        logged;
      logic        stopped_flag;
   } rsp_type;

   // one ring entry as held in the store
   typedef struct packed {
      logic [31:0] event_id;
      logic [31:0] arg_one;
      logic [31:0] arg_two;
      logic [31:0] arg_three;
      logic [31:0] arg_four;
      logic [31:0] thread_tag;
      logic [63:0] time_stamp;
   } entry_type;

   // per-transaction status carried alongside the store read
   typedef struct packed {
      logic entry_valid;
      logic logged;
      logic stopped_flag;
   } status_type;

endpackage

// ----- rtl/tebr_filter.sv -----
// ----------------------------------------------------------------------------
// tebr_filter
// Event id filter: none, class, subclass or inclusive id range.
// ----------------------------------------------------------------------------
module tebr_filter (
   input  logic [1:0]  filter_mode,
   input  logic [31:0] filter_first,
   input  logic [31:0] filter_second,
   input  logic [31:0] event_id,
   output logic        pass
);
   import tebr_pkg::*;

   logic [7:0]  cls;
   logic [7:0]  sub;
   logic [7:0]  cls_inc;
   logic [8:0]  sub_inc;
   logic [31:0] lo;
   logic [31:0] hi;

   assign cls     = filter_first[7:0];
   assign sub     = filter_second[7:0];
   assign cls_inc = cls + 8'd1;
   assign sub_inc = {1'b0, sub} + 9'd1;

   always_comb begin
      lo   = 32'd0;
      hi   = 32'd0;
      pass = 1'b1;
      case (filter_mode)
         FILT_NONE: begin
            pass = 1'b1;
         end
         FILT_CLASS: begin
            lo   = {cls, 24'd0};
            hi   = {cls_inc, 24'd0};
            pass = (event_id >= lo) && (event_id <= hi);
         end
         FILT_SUBCLASS: begin
            // subclass carry ORs into the class byte
            lo   = {cls, sub, 16'd0};
            hi   = {cls, 24'd0} | {7'd0, sub_inc, 16'd0};
            pass = (event_id >= lo) && (event_id <= hi);
         end
         FILT_RANGE: begin
            lo   = filter_first;
            hi   = filter_second;
            pass = (event_id >= lo) && (event_id <= hi);
         end
         default: begin
            pass = 1'b1;
         end
      endcase
   end

endmodule

// ----- rtl/tebr_store.sv -----
// ----------------------------------------------------------------------------
// tebr_store
// Single-write, single-read entry memory with a registered read port.
// ----------------------------------------------------------------------------
module tebr_store #(
   parameter int DEPTH = 8192,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  tebr_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output tebr_pkg::entry_type rd_data
);
   import tebr_pkg::*;

   entry_type ring_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/trace_event_ring_buffer.sv -----
// ----------------------------------------------------------------------------
// trace_event_ring_buffer
// Trace capture ring with event filter, read-oldest and setup operations.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per accepted cycle (req_valid && !req_stall):
//   log an event, read the oldest unread entry, or setup (clear pointers and
//   flags). Every transaction yields exactly one rsp_* transaction.
//   csr_* writes the filter, wrap and size registers; csr_ready is always high.
//   Write registers only while no transaction is in flight.
// Response path: the staged status register, filled alongside the synchronous
//   ring read, then the output register that presents the response.
// Throughput: one transaction per cycle while req_stall is low; pointers live in
//   flops and a log writes the ring in its accept cycle, so a read right behind a log sees it.
// Reset: clears pointers, wrapped/stopped flags and registers. Ring contents
//   are not cleared; no clearing pass is run, so the block is ready at once.
// Stall: rsp_stall holds the output register; once the internal stage is also
//   full, req_stall rises in the same cycle and requests are held off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trace_event_ring_buffer #(
   parameter int DEPTH = 8192
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tebr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tebr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tebr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tebr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tebr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
   localparam logic [31:0]   DEPTH_W = 32'(DEPTH);

   // registers
   logic                     log_enable_ff;
   logic                     no_wrap_ff;
   logic [1:0]               filter_mode_ff;
   logic [31:0]              filter_first_ff;
   logic [31:0]              filter_second_ff;
   logic [BUF_ENTRIES_W-1:0] buffer_entries_ff;

   // pointers and flags
   logic [PW-1:0] wr_idx_ff, wr_idx_in;
   logic [PW-1:0] rd_idx_ff, rd_idx_in;
   logic          wrapped_ff, wrapped_in;
   logic          stopped_ff, stopped_in;

   // pipeline
   logic       p1_valid_ff, p1_valid_in;
   status_type p1_ff, p1_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          p1_move;
   logic          pass;
   logic [31:0]   be_ext;
   logic [PW-1:0] used_n;
   logic          log_ok;
   logic [PW:0]   wr_inc;
   logic [PW:0]   resync;
   logic [PW-1:0] rd_cur;
   logic [PW:0]   rd_inc;
   logic          have_entry;
   logic          mem_wr_en;
   logic          mem_rd_en;
   entry_type     mem_wr_data;
   entry_type     mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_enable_ff     <= 1'b0;
         no_wrap_ff        <= 1'b0;
         filter_mode_ff    <= FILT_NONE;
         filter_first_ff   <= 32'd0;
         filter_second_ff  <= 32'd0;
         buffer_entries_ff <= BUF_ENTRIES_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOG_ENABLE:     log_enable_ff     <= csr_wdata[0];
            CSR_NO_WRAP:        no_wrap_ff        <= csr_wdata[0];
            CSR_FILTER_MODE:    filter_mode_ff    <= csr_wdata[1:0];
            CSR_FILTER_FIRST:   filter_first_ff   <= csr_wdata;
            CSR_FILTER_SECOND:  filter_second_ff  <= csr_wdata;
            CSR_BUFFER_ENTRIES: buffer_entries_ff <= csr_wdata[BUF_ENTRIES_W-1:0];
            default: begin
            end
         endcase
      end
   end

   tebr_filter u_filter (
      .filter_mode   (filter_mode_ff),
      .filter_first  (filter_first_ff),
      .filter_second (filter_second_ff),
      .event_id      (req_data.event_id),
      .pass          (pass)
   );

   // size in use, clamped to 1..DEPTH
   assign be_ext = {{(32 - BUF_ENTRIES_W){1'b0}}, buffer_entries_ff};
   always_comb begin
      if (be_ext == 32'd0) begin
         used_n = PW'(1);
      end else if (be_ext > DEPTH_W) begin
         used_n = DEPTH_P;
      end else begin
         used_n = be_ext[PW-1:0];
      end
   end

   assign p1_move   = p1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign log_ok = log_enable_ff && !stopped_ff && pass && (wr_idx_ff < DEPTH_P);
   assign wr_inc = {1'b0, wr_idx_ff} + {{PW{1'b0}}, 1'b1};
   assign resync = {1'b0, wr_idx_ff} + {{PW{1'b0}}, 1'b1};

   // after a wrap the reader restarts just past the writer
   always_comb begin
      if (wrapped_ff) begin
         rd_cur = (resync >= {1'b0, used_n}) ? {PW{1'b0}} : resync[PW-1:0];
      end else begin
         rd_cur = rd_idx_ff;
      end
   end

   assign have_entry = (rd_cur != wr_idx_ff) && (rd_cur < DEPTH_P);
   assign rd_inc     = {1'b0, rd_cur} + {{PW{1'b0}}, 1'b1};

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      wrapped_in = wrapped_ff;
      stopped_in = stopped_ff;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      p1_in      = '0;
      if (accept) begin
         case (req_data.opcode)
            OP_LOG: begin
               if (log_ok) begin
                  mem_wr_en    = 1'b1;
                  p1_in.logged = 1'b1;
                  if (wr_inc >= {1'b0, used_n}) begin
                     if (no_wrap_ff) begin
                        stopped_in = 1'b1;
                        wr_idx_in  = wr_inc[PW-1:0];
                     end else begin
                        wrapped_in = 1'b1;
                        wr_idx_in  = {PW{1'b0}};
                     end
                  end else begin
                     wr_idx_in = wr_inc[PW-1:0];
                  end
               end
            end
            OP_READ: begin
               wrapped_in = 1'b0;
               rd_idx_in  = rd_cur;
               if (have_entry) begin
                  mem_rd_en         = 1'b1;
                  p1_in.entry_valid = 1'b1;
                  // a stopped ring parks the reader at the end
                  if ((rd_inc >= {1'b0, used_n}) && !stopped_ff) begin
                     rd_idx_in = {PW{1'b0}};
                  end else begin
                     rd_idx_in = rd_inc[PW-1:0];
                  end
               end
            end
            OP_SETUP: begin
               wr_idx_in  = {PW{1'b0}};
               rd_idx_in  = {PW{1'b0}};
               wrapped_in = 1'b0;
               stopped_in = 1'b0;
            end
            default: begin
            end
         endcase
         p1_in.stopped_flag = stopped_in;
      end
   end

   assign mem_wr_data.event_id   = req_data.event_id;
   assign mem_wr_data.arg_one    = req_data.arg_one;
   assign mem_wr_data.arg_two    = req_data.arg_two;
   assign mem_wr_data.arg_three  = req_data.arg_three;
   assign mem_wr_data.arg_four   = req_data.arg_four;
   assign mem_wr_data.thread_tag = req_data.thread_tag;
   assign mem_wr_data.time_stamp = req_data.time_now;

   tebr_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_idx_ff[AW-1:0]),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_cur[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      p1_valid_in = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_ff);
      rsp_valid_in = p1_move ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in = rsp_data_ff;
      if (p1_move) begin
         rsp_data_in              = '0;
         rsp_data_in.entry_valid  = p1_ff.entry_valid;
         rsp_data_in.logged       = p1_ff.logged;
         rsp_data_in.stopped_flag = p1_ff.stopped_flag;
         if (p1_ff.entry_valid) begin
            rsp_data_in.out_event_id   = mem_rd_data.event_id;
            rsp_data_in.out_arg_one    = mem_rd_data.arg_one;
            rsp_data_in.out_arg_two    = mem_rd_data.arg_two;
            rsp_data_in.out_arg_three  = mem_rd_data.arg_three;
            rsp_data_in.out_arg_four   = mem_rd_data.arg_four;
            rsp_data_in.out_thread_tag = mem_rd_data.thread_tag;
            rsp_data_in.out_time       = mem_rd_data.time_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= {PW{1'b0}};
         rd_idx_ff    <= {PW{1'b0}};
         wrapped_ff   <= 1'b0;
         stopped_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         wrapped_ff   <= wrapped_in;
         stopped_ff   <= stopped_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_ff <= p1_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TEBR_ASSERT_IMP(a_wr_idx_in_ring, clock, reset, !stopped_ff,
      wr_idx_ff < DEPTH_P, "write index past ring while not stopped")
   `TEBR_ASSERT_NEXT(a_rd_has_stage, clock, reset, mem_rd_en,
      p1_valid_ff && p1_ff.entry_valid, "ring read without staged transaction")
   `TEBR_ASSERT_IMP(a_empty_read_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.entry_valid,
      rsp_data_ff.out_event_id == 32'd0 && rsp_data_ff.out_time == 64'd0,
      "nonzero payload on response without entry")
   `TEBR_ASSERT_IMP(a_log_or_read, clock, reset, p1_valid_ff,
      !(p1_ff.logged && p1_ff.entry_valid), "transaction both logged and read")

endmodule
